// File: rtl/ascw_pkg.sv
`default_nettype none

package ascw_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE_TARGET = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLEAN_TARGET = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP_STEPS = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0] ONE_Q15 = 16'd32768;
  localparam logic [CFG_DATA_BITS-1:0] RAMP_STEPS_RESET = 16'd4800;

  localparam int GAIN_BITS = 24;
  localparam int GAIN_SHIFT = 7;
  localparam int GAIN_FRAC = 22;
  localparam int DIV_BITS = 23;

  localparam int ARG_BITS = 28;
  localparam int ARG_FRAC = 24;
  localparam int CORDIC_BITS = 31;
  localparam int ANGLE_BITS = 32;
  localparam int ANG_FRAC = 30;
  localparam int ANGLE_IDX_BITS = 5;
  localparam logic [ANGLE_BITS-1:0] ANG_ONE = 32'h4000_0000;

  localparam int WET_BITS = 16;
  localparam logic [WET_BITS-1:0] WET_GAIN = 16'd46334;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ARG,
    ST_ATAN,
    ST_WET,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef enum logic {
    SEL_DRIVE,
    SEL_CLEAN
  } ramp_sel_t;

  typedef struct packed {
    logic                 busy;
    logic [GAIN_BITS-1:0] drive_gain;
    logic [GAIN_BITS-1:0] clean_gain;
  } ramp_status_t;

  // atan(2^-i) scaled so that 1.0 is pi/2, Q.30
  function automatic logic [ANGLE_BITS-1:0] angle_of(input logic [ANGLE_IDX_BITS-1:0] idx);
    logic [ANGLE_BITS-1:0] a;
    case (idx)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2FA;
      5'd15:   a = 32'h0000_517D;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A30;
      5'd19:   a = 32'h0000_0518;
      5'd20:   a = 32'h0000_028C;
      5'd21:   a = 32'h0000_0146;
      5'd22:   a = 32'h0000_00A3;
      5'd23:   a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ascw_ramp.sv
`default_nettype none

module ascw_ramp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ascw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ascw_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                advance,
  output ascw_pkg::ramp_status_t              status
);
  import ascw_pkg::*;

  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_BITS - 1);

  function automatic logic [GAIN_BITS-1:0] gain_of(input logic [CFG_DATA_BITS-1:0] t);
    logic [CFG_DATA_BITS-1:0] c;
    c = (t > ONE_Q15) ? ONE_Q15 : t;
    return GAIN_BITS'(c) << GAIN_SHIFT;
  endfunction

  logic [CFG_DATA_BITS-1:0] drive_target;
  logic [CFG_DATA_BITS-1:0] clean_target;
  logic [CFG_DATA_BITS-1:0] ramp_steps;
  logic [GAIN_BITS-1:0]     drive_now;
  logic [GAIN_BITS-1:0]     drive_step;
  logic [CFG_DATA_BITS-1:0] drive_left;
  logic [GAIN_BITS-1:0]     clean_now;
  logic [GAIN_BITS-1:0]     clean_step;
  logic [CFG_DATA_BITS-1:0] clean_left;

  logic                     div_busy;
  logic [DIV_CNT_BITS-1:0]  div_cnt;
  logic [DIV_BITS-1:0]      div_q;
  logic [CFG_DATA_BITS-1:0] div_rem;
  logic                     div_neg;
  ramp_sel_t                div_sel;

  logic [GAIN_BITS-1:0]     cfg_gain;
  logic [GAIN_BITS-1:0]     drive_gain_tgt;
  logic [GAIN_BITS-1:0]     clean_gain_tgt;
  logic [GAIN_BITS-1:0]     start_now;
  logic [GAIN_BITS:0]       diff;
  logic                     diff_neg;
  logic [DIV_BITS-1:0]      diff_mag;
  logic [CFG_DATA_BITS:0]   div_shift;
  logic                     div_fit;
  logic [CFG_DATA_BITS-1:0] div_rem_next;
  logic [DIV_BITS-1:0]      div_q_next;
  logic [GAIN_BITS-1:0]     q_ext;
  logic [GAIN_BITS-1:0]     step_next;
  logic [GAIN_BITS-1:0]     drive_now_next;
  logic [GAIN_BITS-1:0]     clean_now_next;

  always_comb begin
    cfg_gain       = gain_of(cfg_data);
    drive_gain_tgt = gain_of(drive_target);
    clean_gain_tgt = gain_of(clean_target);
    start_now      = (cfg_index == REG_CLEAN_TARGET) ? clean_now : drive_now;
    diff           = {1'b0, cfg_gain} - {1'b0, start_now};
    diff_neg       = diff[GAIN_BITS];
    diff_mag       = diff_neg ? DIV_BITS'(~diff + 1'b1) : DIV_BITS'(diff);

    // restoring divide, one quotient bit per cycle
    div_shift    = {div_rem, div_q[DIV_BITS-1]};
    div_fit      = div_shift >= {1'b0, ramp_steps};
    div_rem_next = div_fit ? CFG_DATA_BITS'(div_shift - {1'b0, ramp_steps})
                           : div_shift[CFG_DATA_BITS-1:0];
    div_q_next   = {div_q[DIV_BITS-2:0], div_fit};
    q_ext        = {{(GAIN_BITS - DIV_BITS){1'b0}}, div_q_next};
    step_next    = div_neg ? (~q_ext + 1'b1) : q_ext;

    // last step lands on the target
    drive_now_next = (drive_left != 16'd1) ? drive_now + drive_step : drive_gain_tgt;
    clean_now_next = (clean_left != 16'd1) ? clean_now + clean_step : clean_gain_tgt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_target <= '0;
      clean_target <= '0;
      ramp_steps   <= RAMP_STEPS_RESET;
      drive_now    <= '0;
      drive_step   <= '0;
      drive_left   <= '0;
      clean_now    <= '0;
      clean_step   <= '0;
      clean_left   <= '0;
      div_busy     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DRIVE_TARGET: begin
          if (cfg_data != drive_target) begin
            drive_target <= cfg_data;
            if (ramp_steps == '0) begin
              drive_now  <= cfg_gain;
              drive_step <= '0;
              drive_left <= '0;
            end else begin
              drive_left <= ramp_steps;
              div_busy   <= 1'b1;
            end
          end
          clean_now  <= clean_gain_tgt;
          clean_step <= '0;
          clean_left <= '0;
        end
        REG_CLEAN_TARGET: begin
          if (cfg_data != clean_target) begin
            clean_target <= cfg_data;
            if (ramp_steps == '0) begin
              clean_now  <= cfg_gain;
              clean_step <= '0;
              clean_left <= '0;
            end else begin
              clean_left <= ramp_steps;
              div_busy   <= 1'b1;
            end
          end
          drive_now  <= drive_gain_tgt;
          drive_step <= '0;
          drive_left <= '0;
        end
        REG_RAMP_STEPS: begin
          ramp_steps <= cfg_data;
        end
        default: begin
        end
      endcase
    end else if (div_busy) begin
      if (div_cnt == DIV_LAST) begin
        div_busy <= 1'b0;
        if (div_sel == SEL_DRIVE) begin
          drive_step <= step_next;
        end else begin
          clean_step <= step_next;
        end
      end
    end else if (advance) begin
      if (drive_left != '0) begin
        drive_left <= drive_left - 1'b1;
        drive_now  <= drive_now_next;
      end
      if (clean_left != '0) begin
        clean_left <= clean_left - 1'b1;
        clean_now  <= clean_now_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      div_q   <= diff_mag;
      div_rem <= '0;
      div_neg <= diff_neg;
      div_cnt <= '0;
      div_sel <= (cfg_index == REG_CLEAN_TARGET) ? SEL_CLEAN : SEL_DRIVE;
    end else if (div_busy) begin
      div_q   <= div_q_next;
      div_rem <= div_rem_next;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign status.busy       = div_busy;
  assign status.drive_gain = drive_now;
  assign status.clean_gain = clean_now;

endmodule

`default_nettype wire

// File: rtl/atan_soft_clip_waveshaper.sv
// Arctangent soft clipper: y = clean*x + 0.707*(2/pi)*atan(10*drive*x), saturated.
// Input channel (in_valid/in_ready, sample_in) takes one signed sample per item;
// output channel (out_valid/out_ready, sample_out) gives one Q2 result per item.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes drive_target,
// clean_target and ramp_steps. A target write that starts a ramp runs a serial
// divider, during which cfg_ready and in_ready stay low.
// Each item runs through bit-serial multipliers and an iterative CORDIC, one
// item at a time: the block takes no new sample until the result of the last
// one has been loaded into the output register. The steps are load, the dry
// and drive products, argument rounding, the CORDIC, the output gain,
// rounding and the output.
// The finished result sits in an output register; a new item is accepted while
// it waits, and the block holds its last state until out_ready frees it.
// Reset (rst, synchronous) clears both ramps and targets to zero, sets the
// ramp length to 4800 and empties the output register.
`default_nettype none

module atan_soft_clip_waveshaper #(
  parameter int SAMPLE_BITS = 16,
  parameter int ATAN_STEPS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS:0]         sample_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ascw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ascw_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ascw_pkg::*;

  localparam int MUL_BITS   = SAMPLE_BITS + 3;
  localparam int ACC_BITS   = GAIN_BITS + 1;
  localparam int PROD_BITS  = ACC_BITS + MUL_BITS;
  localparam int DRY_SHIFT  = GAIN_FRAC;
  localparam int ARG_SHIFT  = SAMPLE_BITS - 1 + GAIN_FRAC - ARG_FRAC;
  localparam int ZC_BITS    = ANG_FRAC + 1;
  localparam int WACC_BITS  = ZC_BITS + 1;
  localparam int WPROD_BITS = WACC_BITS + WET_BITS;
  localparam int WET_SHIFT  = ANG_FRAC + WET_BITS - (SAMPLE_BITS - 1);
  localparam int CNT_MAX0   = (MUL_BITS > ATAN_STEPS) ? MUL_BITS : ATAN_STEPS;
  localparam int CNT_MAX    = (CNT_MAX0 > WET_BITS) ? CNT_MAX0 : WET_BITS;
  localparam int CNT_BITS   = $clog2(CNT_MAX);
  localparam logic [CNT_BITS-1:0] MUL_LAST  = CNT_BITS'(MUL_BITS - 1);
  localparam logic [CNT_BITS-1:0] ATAN_LAST = CNT_BITS'(ATAN_STEPS - 1);
  localparam logic [CNT_BITS-1:0] WET_LAST  = CNT_BITS'(WET_BITS - 1);
  localparam logic [SAMPLE_BITS:0] POS_LIM  = {1'b0, {SAMPLE_BITS{1'b1}}};
  localparam logic [SAMPLE_BITS:0] NEG_LIM  = {1'b1, {SAMPLE_BITS{1'b0}}};

  state_t state;
  state_t state_next;

  ramp_status_t ramp;
  logic         cfg_we;
  logic         accept;
  logic         load_out;

  logic [CNT_BITS-1:0]            cnt;
  logic [SAMPLE_BITS-1:0]         x;
  logic                           neg;
  logic [MUL_BITS-1:0]            mul_c;
  logic [MUL_BITS-1:0]            mul_d;
  logic [ACC_BITS-1:0]            acc_c;
  logic [ACC_BITS-1:0]            acc_d;
  logic [MUL_BITS-1:0]            low_c;
  logic [MUL_BITS-1:0]            low_d;
  logic [SAMPLE_BITS-1:0]         dry_mag;
  logic                           arg_zero;
  logic signed [CORDIC_BITS-1:0]  cx;
  logic signed [CORDIC_BITS-1:0]  cy;
  logic signed [ANGLE_BITS-1:0]   z;
  logic [WET_BITS-1:0]            wet_m;
  logic [WACC_BITS-1:0]           acc_w;
  logic [WET_BITS-1:0]            low_w;
  logic [SAMPLE_BITS-1:0]         wet_mag;

  logic [SAMPLE_BITS-1:0]         ax;
  logic [ACC_BITS-1:0]            acc_c_sum;
  logic [ACC_BITS-1:0]            acc_d_sum;
  logic [PROD_BITS-1:0]           prod_c;
  logic [PROD_BITS-1:0]           prod_d;
  logic [ARG_BITS-1:0]            arg_next;
  logic [SAMPLE_BITS-1:0]         dry_next;
  logic signed [CORDIC_BITS-1:0]  sx;
  logic signed [CORDIC_BITS-1:0]  sy;
  logic signed [ANGLE_BITS-1:0]   ang;
  logic [ZC_BITS-1:0]             zc;
  logic [WACC_BITS-1:0]           acc_w_sum;
  logic [WPROD_BITS-1:0]          prod_w;
  logic [SAMPLE_BITS-1:0]         wet_next;
  logic [SAMPLE_BITS:0]           sum_mag;
  logic [SAMPLE_BITS:0]           sat_mag;
  logic [SAMPLE_BITS:0]           y_next;

  ascw_ramp u_ramp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .status    (ramp)
  );

  assign cfg_ready = (state == ST_IDLE) && !ramp.busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    accept     = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !ramp.busy && !cfg_valid;
        if (in_valid && in_ready) begin
          accept     = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (cnt == MUL_LAST) begin
          state_next = ST_ARG;
        end
      end
      ST_ARG: begin
        state_next = ST_ATAN;
      end
      ST_ATAN: begin
        if (cnt == ATAN_LAST) begin
          state_next = ST_WET;
        end
      end
      ST_WET: begin
        if (cnt == WET_LAST) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ax        = x[SAMPLE_BITS-1] ? SAMPLE_BITS'(~x + 1'b1) : x;
    acc_c_sum = acc_c + (mul_c[0] ? {1'b0, ramp.clean_gain} : '0);
    acc_d_sum = acc_d + (mul_d[0] ? {1'b0, ramp.drive_gain} : '0);
    prod_c    = {acc_c, low_c};
    prod_d    = {acc_d, low_d};
    arg_next  = prod_d[ARG_SHIFT +: ARG_BITS] + ARG_BITS'(prod_d[ARG_SHIFT-1]);
    dry_next  = prod_c[DRY_SHIFT +: SAMPLE_BITS] + SAMPLE_BITS'(prod_c[DRY_SHIFT-1]);

    sx  = cx >>> cnt;
    sy  = cy >>> cnt;
    ang = $signed(angle_of(ANGLE_IDX_BITS'(cnt)));

    if (arg_zero || z[ANGLE_BITS-1]) begin
      zc = '0;
    end else if ($unsigned(z) > ANG_ONE) begin
      zc = ANG_ONE[ZC_BITS-1:0];
    end else begin
      zc = z[ZC_BITS-1:0];
    end
    acc_w_sum = acc_w + (wet_m[0] ? {1'b0, zc} : '0);
    prod_w    = {acc_w, low_w};
    wet_next  = prod_w[WET_SHIFT +: SAMPLE_BITS] + SAMPLE_BITS'(prod_w[WET_SHIFT-1]);

    sum_mag = {1'b0, dry_mag} + {1'b0, wet_mag};
    if (neg) begin
      sat_mag = (sum_mag > NEG_LIM) ? NEG_LIM : sum_mag;
      y_next  = ~sat_mag + 1'b1;
    end else begin
      sat_mag = (sum_mag > POS_LIM) ? POS_LIM : sum_mag;
      y_next  = sat_mag;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          x <= sample_in;
        end
      end
      ST_LOAD: begin
        neg   <= x[SAMPLE_BITS-1];
        mul_c <= MUL_BITS'(ax);
        mul_d <= {ax, 3'b000} + {2'b00, ax, 1'b0};
        acc_c <= '0;
        acc_d <= '0;
        cnt   <= '0;
      end
      ST_MUL: begin
        acc_c <= acc_c_sum >> 1;
        acc_d <= acc_d_sum >> 1;
        low_c <= {acc_c_sum[0], low_c[MUL_BITS-1:1]};
        low_d <= {acc_d_sum[0], low_d[MUL_BITS-1:1]};
        mul_c <= mul_c >> 1;
        mul_d <= mul_d >> 1;
        cnt   <= (cnt == MUL_LAST) ? '0 : cnt + 1'b1;
      end
      ST_ARG: begin
        dry_mag  <= dry_next;
        arg_zero <= (arg_next == '0);
        cx       <= CORDIC_BITS'(1) << ARG_FRAC;
        cy       <= CORDIC_BITS'(arg_next);
        z        <= '0;
        cnt      <= '0;
      end
      ST_ATAN: begin
        if (!cy[CORDIC_BITS-1]) begin
          cx <= cx + sy;
          cy <= cy - sx;
          z  <= z + ang;
        end else begin
          cx <= cx - sy;
          cy <= cy + sx;
          z  <= z - ang;
        end
        if (cnt == ATAN_LAST) begin
          cnt   <= '0;
          wet_m <= WET_GAIN;
          acc_w <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      ST_WET: begin
        acc_w <= acc_w_sum >> 1;
        low_w <= {acc_w_sum[0], low_w[WET_BITS-1:1]};
        wet_m <= wet_m >> 1;
        cnt   <= (cnt == WET_LAST) ? '0 : cnt + 1'b1;
      end
      ST_ROUND: begin
        wet_mag <= wet_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_out <= y_next;
    end
  end

endmodule

`default_nettype wire

// File: bench/waveshaper_monitor.sv
module waveshaper_monitor #(
  parameter int SAMPLE_BITS = 16,
  parameter int ATAN_STEPS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [SAMPLE_BITS:0]         sample_out,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [ascw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ascw_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  results_seen
);
  import ascw_pkg::*;

  // atan(2^-i) in Q.30, 1.0 = pi/2
  localparam logic [0:23][31:0] ANGLES = {
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43, 32'h0145_D7E1,
    32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D, 32'h0000_28BE, 32'h0000_145F,
    32'h0000_0A30, 32'h0000_0518, 32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  logic [CFG_DATA_BITS-1:0] target [2];
  logic [GAIN_BITS-1:0]     gain [2];
  int                       step [2];
  logic [15:0]              left [2];
  logic [15:0]              ramp_len;

  logic signed [SAMPLE_BITS:0] shaped_q [$];
  logic signed [SAMPLE_BITS:0] want;

  function automatic logic [GAIN_BITS-1:0] target_gain(input logic [CFG_DATA_BITS-1:0] r);
    logic [GAIN_BITS-1:0] g;
    g = GAIN_BITS'((r > ONE_Q15) ? ONE_Q15 : r);
    return g << GAIN_SHIFT;
  endfunction

  function automatic longint round_sh(input longint v, input int s);
    longint m;
    longint r;
    m = (v < 0) ? -v : v;
    r = (m + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -r : r;
  endfunction

  // (2/pi)*atan(a), a >= 0 in Q.24, result Q.30
  function automatic longint atan_q30(input longint a);
    longint cx;
    longint cy;
    longint z;
    longint sx;
    longint sy;
    cx = longint'(1) << ARG_FRAC;
    cy = a;
    z = 0;
    if (a == 0) return 0;
    for (int i = 0; i < ATAN_STEPS && i < 24; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (cy >= 0) begin
        cx = cx + sy;
        cy = cy - sx;
        z = z + longint'(ANGLES[i]);
      end else begin
        cx = cx - sy;
        cy = cy + sx;
        z = z - longint'(ANGLES[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(ANG_ONE)) z = longint'(ANG_ONE);
    return z;
  endfunction

  task automatic start_ramp(input ramp_sel_t s);
    if (ramp_len == 0) begin
      gain[s] = target_gain(target[s]);
      step[s] = 0;
      left[s] = '0;
    end else begin
      step[s] = (int'(target_gain(target[s])) - int'(gain[s])) / int'(ramp_len);
      left[s] = ramp_len;
    end
  endtask

  task automatic snap_ramp(input ramp_sel_t s);
    gain[s] = target_gain(target[s]);
    step[s] = 0;
    left[s] = '0;
  endtask

  task automatic advance_ramp(input ramp_sel_t s);
    if (left[s] != 0) begin
      left[s] = left[s] - 16'd1;
      if (left[s] != 0) gain[s] = GAIN_BITS'(int'(gain[s]) + step[s]);
      else gain[s] = target_gain(target[s]);
    end
  endtask

  task automatic apply_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      REG_DRIVE_TARGET: begin
        if (val != target[SEL_DRIVE]) begin
          target[SEL_DRIVE] = val;
          start_ramp(SEL_DRIVE);
        end
        snap_ramp(SEL_CLEAN);
      end
      REG_CLEAN_TARGET: begin
        if (val != target[SEL_CLEAN]) begin
          target[SEL_CLEAN] = val;
          start_ramp(SEL_CLEAN);
        end
        snap_ramp(SEL_DRIVE);
      end
      REG_RAMP_STEPS: ramp_len = val;
      default: ;
    endcase
  endtask

  function automatic logic signed [SAMPLE_BITS:0] shaped(input logic signed [SAMPLE_BITS-1:0] xin);
    longint x;
    longint lim;
    longint dry;
    longint prod;
    longint arg;
    longint wet;
    longint y;
    x = longint'(xin);
    lim = longint'(1) << SAMPLE_BITS;
    dry = round_sh(longint'(gain[SEL_CLEAN]) * x, GAIN_FRAC);
    prod = longint'(gain[SEL_DRIVE]) * ((x < 0) ? -x : x) * 10;
    arg = round_sh(prod, SAMPLE_BITS - 1 + GAIN_FRAC - ARG_FRAC);
    wet = round_sh(atan_q30(arg) * longint'(WET_GAIN), 47 - SAMPLE_BITS);
    if (x < 0) wet = -wet;
    y = dry + wet;
    if (y > lim - 1) y = lim - 1;
    if (y < -lim) y = -lim;
    return y[SAMPLE_BITS:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        target[i] = '0;
        gain[i] = '0;
        step[i] = 0;
        left[i] = '0;
      end
      ramp_len = RAMP_STEPS_RESET;
      shaped_q.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        advance_ramp(SEL_DRIVE);
        advance_ramp(SEL_CLEAN);
        shaped_q.push_back(shaped(sample_in));
      end
      if (out_valid && out_ready) begin
        results_seen = results_seen + 1;
        if (shaped_q.size() == 0) begin
          if (mismatches < 10) $display("sample_out %0d arrived with no item pending", sample_out);
          mismatches = mismatches + 1;
        end else begin
          want = shaped_q.pop_front();
          if (want !== sample_out) begin
            if (mismatches < 10)
              $display("sample_out mismatch at result %0d: expected %0d, got %0d",
                       results_seen, want, sample_out);
            mismatches = mismatches + 1;
          end
        end
      end
    end
    outstanding <= shaped_q.size();
  end

endmodule

// File: bench/testbench.sv
module testbench;
  import ascw_pkg::*;

  localparam int SAMPLE_BITS = 16;
  localparam int ATAN_STEPS  = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 85;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS:0]   sample_out;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_INDEX_BITS-1:0]     cfg_index;
  logic [CFG_DATA_BITS-1:0]      cfg_data;

  int mismatches;
  int outstanding;
  int results_seen;
  int cycles;
  int items_sent;
  int writes_done;
  int hold_ask;
  int hold_done;
  bit quiet;

  atan_soft_clip_waveshaper #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ATAN_STEPS (ATAN_STEPS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  waveshaper_monitor #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ATAN_STEPS (ATAN_STEPS)
  ) mon (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_in   (sample_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles = cycles + 1;
    end
    $display("cycle limit reached with %0d results still pending", outstanding);
    $display("== FAIL ==");
    $finish;
  end

  // output side: random back-pressure, one long hold on request
  initial begin
    hold_done = 0;
    out_ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_ask != hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = hold_done + 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] s, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
    items_sent = items_sent + 1;
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    writes_done = writes_done + 1;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_target();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return ONE_Q15;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  initial begin
    logic signed [SAMPLE_BITS-1:0] s;
    logic [CFG_DATA_BITS-1:0] d_tgt;
    logic [CFG_DATA_BITS-1:0] c_tgt;
    logic [CFG_DATA_BITS-1:0] r;
    bit gappy;
    int gap;

    rst = 1'b1;
    in_valid = 1'b0;
    sample_in = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DRIVE_TARGET;
    cfg_data = '0;
    quiet = 1'b0;
    hold_ask = 0;
    items_sent = 0;
    writes_done = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zero drive and zero dry gain after reset
    offer_sample(16'sh7FFF, 0);
    offer_sample(16'sh8000, 0);
    settle();

    // full gains taken at once, extremes of the sample
    cfg_write(REG_RAMP_STEPS, 16'd0);
    cfg_write(REG_DRIVE_TARGET, ONE_Q15);
    cfg_write(REG_CLEAN_TARGET, ONE_Q15);
    cfg_valid <= 1'b0;
    offer_sample(16'sh0000, 0);
    offer_sample(16'sh7FFF, 0);
    offer_sample(16'sh8000, 0);
    offer_sample(16'sh0001, 0);
    offer_sample(16'shFFFF, 0);
    offer_sample(16'sh5555, 0);
    offer_sample(16'shAAAA, 0);
    settle();

    // targets above one
    cfg_write(REG_DRIVE_TARGET, 16'hFFFF);
    cfg_write(REG_CLEAN_TARGET, 16'hFFFF);
    cfg_valid <= 1'b0;
    offer_sample(16'sh7FFF, 0);
    offer_sample(16'sh8000, 0);
    offer_sample(16'sh0064, 0);
    settle();

    // short ramp, then the same value rewritten mid-ramp
    cfg_write(REG_RAMP_STEPS, 16'd5);
    cfg_write(REG_DRIVE_TARGET, 16'd1000);
    cfg_valid <= 1'b0;
    offer_sample(16'sh4000, 0);
    offer_sample(16'shC000, 0);
    offer_sample(16'sh1234, 0);
    settle();
    cfg_write(REG_DRIVE_TARGET, 16'd1000);
    cfg_valid <= 1'b0;
    offer_sample(16'sh7FFF, 0);
    offer_sample(16'sh8000, 0);
    offer_sample(16'sh0100, 0);
    settle();

    // one-step ramp of the dry gain, drive snaps
    cfg_write(REG_RAMP_STEPS, 16'd1);
    cfg_write(REG_CLEAN_TARGET, 16'd0);
    cfg_valid <= 1'b0;
    offer_sample(16'sh7FFF, 0);
    offer_sample(16'sh8001, 0);
    settle();

    // unknown index changes nothing
    cfg_write(REG_UNUSED, 16'hFFFF);
    cfg_valid <= 1'b0;
    offer_sample(16'sh2000, 0);
    offer_sample(16'shE000, 0);
    settle();

    // longest ramp length
    cfg_write(REG_RAMP_STEPS, 16'hFFFF);
    cfg_write(REG_DRIVE_TARGET, 16'd0);
    cfg_valid <= 1'b0;
    offer_sample(16'sh7FFF, 0);
    offer_sample(16'sh8000, 0);

    d_tgt = 16'd0;
    c_tgt = 16'd0;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p >= PHASES - 2) quiet <= 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 6))
          0: r = 16'd0;
          1: r = 16'd1;
          2: r = 16'($urandom_range(2, 16));
          3: r = 16'($urandom_range(17, 90));
          4: r = 16'hFFFF;
          default: r = 16'($urandom_range(2, 40));
        endcase
        cfg_write(REG_RAMP_STEPS, r);
      end
      if ($urandom_range(0, 7) == 0) cfg_write(REG_UNUSED, 16'($urandom));
      d_tgt = pick_target();
      c_tgt = pick_target();
      if ($urandom_range(0, 1)) begin
        cfg_write(REG_DRIVE_TARGET, d_tgt);
        cfg_write(REG_CLEAN_TARGET, c_tgt);
      end else begin
        cfg_write(REG_CLEAN_TARGET, c_tgt);
        cfg_write(REG_DRIVE_TARGET, d_tgt);
      end
      cfg_valid <= 1'b0;
      if (p == 3) hold_ask <= hold_ask + 1;
      gappy = (p < PHASES - 2) && ($urandom_range(0, 2) != 0);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) begin
          settle();
          if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 1)) d_tgt = pick_target();
            cfg_write(REG_DRIVE_TARGET, d_tgt);
          end else begin
            if ($urandom_range(0, 1)) c_tgt = pick_target();
            cfg_write(REG_CLEAN_TARGET, c_tgt);
          end
          cfg_valid <= 1'b0;
        end
        case ($urandom_range(0, 7))
          0: begin
            case ($urandom_range(0, 4))
              0: s = 16'sh7FFF;
              1: s = 16'sh8000;
              2: s = 16'sh0000;
              3: s = 16'sh0001;
              default: s = 16'shFFFF;
            endcase
          end
          1, 2: begin
            s = 16'($urandom_range(0, 255));
            if ($urandom_range(0, 1)) s = -s;
          end
          3: begin
            s = 16'($urandom_range(0, 4095));
            if ($urandom_range(0, 1)) s = -s;
          end
          default: s = 16'($urandom);
        endcase
        gap = (gappy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        offer_sample(s, gap);
      end
    end

    settle();
    repeat (100) @(posedge clk);
    $display("%0d samples sent and %0d results checked, %0d register writes",
             items_sent, results_seen, writes_done);
    $display("covered full-scale samples, gains above one, ramps of 0 to 65535 steps, one long stall");
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, outstanding);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
